>>> rtl/core/dseg_pkg.sv
// Package for the dip segmenter: sizes, reset values and state encodings.
// Depends on nothing; imported by dip_segmenter_core.
`timescale 1ns / 1ps

package dseg_pkg;

  localparam int PATTERN_LEN = 50;
  localparam int STORE_DEPTH = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int POS_W  = $clog2(PATTERN_LEN);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = POS_W + 1;
  localparam int SEGC_W = 16;
  localparam int DIR_W  = 2;

  localparam logic signed [SAMPLE_BITS-1:0] THR_RESET = SAMPLE_BITS'(-176);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_TAIL,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef enum logic {
    PH_WAIT,
    PH_DIP
  } phase_t;

endpackage

>>> rtl/core/dip_segmenter_core.sv
// Dip segmenter top level: sequencer, shared signed comparator and sample memory.
// Depends on dseg_pkg for sizes, reset values and state encodings.
`timescale 1ns / 1ps

// How to use this block:
// Input transactions arrive on in_valid / in_stall. A transaction with cmd low
// carries one triaxial sample; cmd high marks end of data and closes the
// current segment. Results leave on out_valid / out_stall, one transaction per
// position of the emitted pattern, PATTERN_LEN transactions per cut, the last
// one marked by last.
// A plain sample occupies the block in these steps: one to take the
// transaction, one to store it and compare z against the window minimum or
// the threshold, and, inside a dip window or when the sample opens one, one
// more to store the tail copy and check z against the threshold. A single
// signed comparator and the single write port of the sample memory make these
// steps separate. At a cut, each result transaction passes through a memory
// read state and then a presentation state. While the receiver stalls, the
// presented result holds and no input transaction is taken. in_stall is high
// whenever the block is busy. The threshold register is to be written over
// cfg_valid / cfg_ready only while idle; the block itself does not enforce
// this. Synchronous reset returns the sequencer to idle, clears all counters
// and restores the threshold to its reset value; the memory needs no clearing.
module dip_segmenter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic signed [dseg_pkg::SAMPLE_BITS-1:0] cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [dseg_pkg::SAMPLE_BITS-1:0] x_sample,
  input  logic signed [dseg_pkg::SAMPLE_BITS-1:0] y_sample,
  input  logic signed [dseg_pkg::SAMPLE_BITS-1:0] z_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dseg_pkg::DIR_W-1:0]           direction_label,
  output logic [dseg_pkg::SEGC_W-1:0]          pattern_number,
  output logic [dseg_pkg::POS_W-1:0]           position,
  output logic signed [dseg_pkg::SAMPLE_BITS-1:0] x_value,
  output logic signed [dseg_pkg::SAMPLE_BITS-1:0] y_value,
  output logic                                 is_padding,
  output logic                                 truncated,
  output logic                                 last
);
  import dseg_pkg::*;

  localparam logic [CNT_W-1:0] LEN_C   = CNT_W'(PATTERN_LEN);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PATTERN_LEN - 1);

  state_t state, state_next;
  phase_t phase;

  logic signed [SAMPLE_BITS-1:0] thr;
  logic signed [SAMPLE_BITS-1:0] win_min;
  logic [CNT_W-1:0]  min_index;
  logic [CNT_W-1:0]  write_index;
  logic [CNT_W-1:0]  tail_len;
  logic [SEGC_W-1:0] seg_count;
  // Bank holding the current segment; the other bank collects the tail from
  // the window minimum on, and the two swap roles when a dip window closes.
  logic              seg_bank;

  logic signed [SAMPLE_BITS-1:0] x_r, y_r, z_r;
  logic              was_dip;
  logic              tail_we;
  logic [POS_W-1:0]  tail_addr;
  logic [CNT_W-1:0]  emit_len;
  logic              emit_end;
  logic [POS_W-1:0]  pos;

  // Sample memory: both banks, {bank, position}.
  logic [2*SAMPLE_BITS-1:0] mem [2**ADDR_W];
  logic [ADDR_W-1:0]        mem_waddr;
  logic [ADDR_W-1:0]        mem_raddr;
  logic                     mem_we;
  logic                     mem_re;
  logic signed [SAMPLE_BITS-1:0] rd_x, rd_y;

  // Shared comparator: le_a <= le_b, signed.
  logic signed [SAMPLE_BITS-1:0] le_a, le_b;
  logic le;

  logic in_acc;
  logic out_acc;
  logic real_pos;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == ST_SHOW);
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    case (state)
      ST_TAIL: begin
        le_a = thr;
        le_b = z_r;
      end
      default: begin
        le_a = z_r;
        le_b = (phase == PH_DIP) ? win_min : thr;
      end
    endcase
  end
  assign le = (le_a <= le_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = {seg_bank, write_index[POS_W-1:0]};
    mem_raddr  = {seg_bank, pos};
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = cmd ? ST_READ : ST_SEG;
        end
      end
      ST_SEG: begin
        mem_we = (write_index < LEN_C);
        if (phase == PH_DIP || le) begin
          state_next = ST_TAIL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TAIL: begin
        mem_we    = tail_we;
        mem_waddr = {~seg_bank, tail_addr};
        state_next = (was_dip && le) ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_acc) begin
          state_next = (pos == LAST_POS) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {x_r, y_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      {rd_x, rd_y} <= mem[mem_raddr];
    end
  end

  // Payload registers of the current sample and the tail write.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= x_sample;
      y_r <= y_sample;
      z_r <= z_sample;
    end
    if (state == ST_SEG) begin
      was_dip <= (phase == PH_DIP);
      if (phase == PH_WAIT || le) begin
        tail_addr <= '0;
      end else begin
        tail_addr <= tail_len[POS_W-1:0];
      end
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr         <= THR_RESET;
      phase       <= PH_WAIT;
      win_min     <= '0;
      min_index   <= '0;
      write_index <= '0;
      tail_len    <= '0;
      seg_count   <= '0;
      seg_bank    <= 1'b0;
      tail_we     <= 1'b0;
      emit_len    <= '0;
      emit_end    <= 1'b0;
      pos         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && cmd) begin
            emit_len <= (phase == PH_DIP) ? min_index : write_index;
            emit_end <= 1'b1;
            pos      <= '0;
          end
        end
        ST_SEG: begin
          if (write_index < DEPTH_C) begin
            write_index <= write_index + CNT_W'(1);
          end
          tail_we <= 1'b0;
          if (le) begin
            // New window, or a new minimum inside the window: restart the tail.
            phase     <= PH_DIP;
            win_min   <= z_r;
            min_index <= write_index;
            tail_we   <= 1'b1;
            tail_len  <= CNT_W'(1);
          end else if (phase == PH_DIP) begin
            tail_we <= (tail_len < LEN_C);
            if (tail_len < DEPTH_C) begin
              tail_len <= tail_len + CNT_W'(1);
            end
          end
        end
        ST_TAIL: begin
          if (was_dip && le) begin
            emit_len <= min_index;
            emit_end <= 1'b0;
            pos      <= '0;
          end
        end
        ST_SHOW: begin
          if (out_acc) begin
            if (pos == LAST_POS) begin
              if (emit_end) begin
                phase       <= PH_WAIT;
                win_min     <= '0;
                min_index   <= '0;
                write_index <= '0;
                tail_len    <= '0;
                seg_count   <= '0;
              end else begin
                seg_bank    <= ~seg_bank;
                write_index <= tail_len;
                phase       <= PH_WAIT;
                seg_count   <= seg_count + SEGC_W'(1);
              end
            end else begin
              pos <= pos + POS_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign real_pos        = (CNT_W'(pos) < emit_len);
  assign direction_label = seg_count[DIR_W-1:0];
  assign pattern_number  = SEGC_W'(((SEGC_W + 1)'(seg_count) + (SEGC_W + 1)'(3)) >> 2);
  assign position        = pos;
  assign x_value         = real_pos ? rd_x : '0;
  assign y_value         = real_pos ? rd_y : '0;
  assign is_padding      = !real_pos;
  assign truncated       = (emit_len > LEN_C);
  assign last            = (pos == LAST_POS);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_acc))
    else $error("input taken while a result is presented");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (write_index <= DEPTH_C) && (tail_len <= DEPTH_C))
    else $error("sample counters beyond store depth");

  a_tail_in_seg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && phase == PH_DIP) |->
      (tail_len <= write_index && min_index <= write_index))
    else $error("tail or minimum lies outside the segment");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last) |=> (state == ST_IDLE))
    else $error("pattern did not end after its last item");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos <= LAST_POS))
    else $error("position beyond the pattern");
`endif

endmodule

>>> test/dip_segmenter_core_tb.sv
// Self-checking testbench for dip_segmenter_core: directed table plus random dip gestures.
// Depends on dseg_pkg and dip_segmenter_core; results are checked against a local model.
`timescale 1ns / 1ps

module dip_segmenter_core_tb;
  import dseg_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  // Extra cycles after the last expected result, for a trailing plain sample to finish.
  localparam int DRAIN_CYCLES = 16;
  // Length of the long receiver hold-off that forces the block to back up.
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 100;
  localparam int SW = SAMPLE_BITS;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic [DIR_W-1:0]  dir;
    logic [SEGC_W-1:0] pnum;
    logic [POS_W-1:0]  pos;
    logic signed [SW-1:0] xv;
    logic signed [SW-1:0] yv;
    logic pad;
    logic trunc;
    logic fin;
  } pat_item_t;

  // One row of the directed table. When hand_chk is set, the pattern header
  // and the number of real positions are typed in rather than predicted.
  typedef struct packed {
    logic eod;
    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] ys;
    logic signed [SW-1:0] zs;
    logic hand_chk;
    logic [DIR_W-1:0]  dir;
    logic [SEGC_W-1:0] pnum;
    logic [7:0]        len;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic signed [SW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          cmd = 1'b0;
  logic signed [SW-1:0] x_sample = '0;
  logic signed [SW-1:0] y_sample = '0;
  logic signed [SW-1:0] z_sample = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [DIR_W-1:0]  direction_label;
  logic [SEGC_W-1:0] pattern_number;
  logic [POS_W-1:0]  position;
  logic signed [SW-1:0] x_value;
  logic signed [SW-1:0] y_value;
  logic          is_padding;
  logic          truncated;
  logic          last;

  dip_segmenter_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .x_sample(x_sample),
    .y_sample(y_sample),
    .z_sample(z_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .direction_label(direction_label),
    .pattern_number(pattern_number),
    .position(position),
    .x_value(x_value),
    .y_value(y_value),
    .is_padding(is_padding),
    .truncated(truncated),
    .last(last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Segmentation model. It tracks the dip window, the samples of the current
  // segment and the samples from the window minimum on, and queues the 50
  // expected pattern items at every cut.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] dip_thr;
  logic signed [SW-1:0] win_min;
  phase_t               win_phase;
  int unsigned          win_min_idx;
  int unsigned          seg_len;   // samples in the segment, saturating at STORE_DEPTH
  int unsigned          tail_cnt;  // samples from the window minimum on, saturating too
  logic [SEGC_W-1:0]    seg_cnt;
  logic signed [SW-1:0] seg_xs [PATTERN_LEN];
  logic signed [SW-1:0] seg_ys [PATTERN_LEN];
  logic signed [SW-1:0] tail_xs [PATTERN_LEN];
  logic signed [SW-1:0] tail_ys [PATTERN_LEN];

  pat_item_t pattern_q [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  function automatic void restart_stream();
    win_phase = PH_WAIT;
    win_min = '0;
    win_min_idx = 0;
    seg_len = 0;
    tail_cnt = 0;
    seg_cnt = '0;
    foreach (seg_xs[i]) begin
      seg_xs[i] = '0;
      seg_ys[i] = '0;
      tail_xs[i] = '0;
      tail_ys[i] = '0;
    end
  endfunction

  // Queues one full pattern built from the first len samples of the segment.
  function automatic void queue_pattern(int unsigned len);
    int unsigned pnum;
    pat_item_t it;
    pnum = (int'(seg_cnt) + 3) / 4;
    for (int p = 0; p < PATTERN_LEN; p++) begin
      it.dir   = seg_cnt[DIR_W-1:0];
      it.pnum  = (pnum > 65535) ? '1 : SEGC_W'(pnum);
      it.pos   = POS_W'(p);
      it.pad   = (p >= len);
      it.xv    = it.pad ? '0 : seg_xs[p];
      it.yv    = it.pad ? '0 : seg_ys[p];
      it.trunc = (len > PATTERN_LEN);
      it.fin   = (p == PATTERN_LEN - 1);
      pattern_q.push_back(it);
    end
    seg_cnt = seg_cnt + SEGC_W'(1);
  endfunction

  function automatic void track_item(logic eod, logic signed [SW-1:0] xs,
                                     logic signed [SW-1:0] ys, logic signed [SW-1:0] zs);
    int unsigned off;
    if (eod) begin
      // End of data inside a window cuts at the minimum; otherwise after the last sample.
      queue_pattern(win_phase == PH_DIP ? win_min_idx : seg_len);
      restart_stream();
      return;
    end
    off = seg_len;
    if (off < PATTERN_LEN) begin
      seg_xs[off] = xs;
      seg_ys[off] = ys;
    end
    if (seg_len < STORE_DEPTH) seg_len++;
    if (win_phase != PH_DIP) begin
      if (zs <= dip_thr) begin
        win_phase = PH_DIP;
        win_min = zs;
        win_min_idx = off;
        tail_xs[0] = xs;
        tail_ys[0] = ys;
        tail_cnt = 1;
      end
      return;
    end
    if (zs <= win_min) begin
      // A tie moves the minimum to the later sample.
      win_min = zs;
      win_min_idx = off;
      tail_xs[0] = xs;
      tail_ys[0] = ys;
      tail_cnt = 1;
    end else begin
      if (tail_cnt < PATTERN_LEN) begin
        tail_xs[tail_cnt] = xs;
        tail_ys[tail_cnt] = ys;
      end
      if (tail_cnt < STORE_DEPTH) tail_cnt++;
    end
    if (zs >= dip_thr) begin
      // The closing sample is part of the window; the next segment starts at the minimum.
      queue_pattern(win_min_idx);
      seg_xs = tail_xs;
      seg_ys = tail_ys;
      seg_len = tail_cnt;
      win_phase = PH_WAIT;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. The payload is presented with valid and held until the block
  // takes the transaction; random gaps are inserted before each one.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic eod, logic signed [SW-1:0] xs,
                           logic signed [SW-1:0] ys, logic signed [SW-1:0] zs);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= eod;
    x_sample <= xs;
    y_sample <= ys;
    z_sample <= zs;
    do @(posedge clk); while (in_stall);
    track_item(eod, xs, ys, zs);
    items_sent++;
  endtask

  function automatic logic signed [SW-1:0] rnd_sample();
    return SW'($urandom);
  endfunction

  // z values at a random distance above or below the current threshold, clamped.
  function automatic logic signed [SW-1:0] z_high();
    int v;
    v = int'(dip_thr) + int'($urandom_range(1, 3000));
    if (v > 32767) v = 32767;
    return SW'(v);
  endfunction

  function automatic logic signed [SW-1:0] z_low();
    int v;
    v = int'(dip_thr) - int'($urandom_range(1, 3000));
    if (v < -32768) v = -32768;
    return SW'(v);
  endfunction

  // One dip gesture: resting samples, a dip with occasional ties at the
  // minimum, then a closing sample. A few gestures are pure noise, and some
  // end the stream in the middle of the dip.
  task automatic send_gesture();
    int roll;
    int lead;
    int dips;
    logic signed [SW-1:0] zs;
    logic signed [SW-1:0] lowest;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6)) send_item(1'b0, rnd_sample(), rnd_sample(), rnd_sample());
      return;
    end
    lead = ($urandom_range(0, 7) == 0) ? $urandom_range(45, 60) : $urandom_range(0, 10);
    repeat (lead) send_item(1'b0, rnd_sample(), rnd_sample(), z_high());
    dips = $urandom_range(1, 6);
    lowest = z_low();
    for (int i = 0; i < dips; i++) begin
      zs = ($urandom_range(0, 3) == 0) ? lowest : z_low();
      if (zs < lowest) lowest = zs;
      send_item(1'b0, rnd_sample(), rnd_sample(), zs);
    end
    if (roll < 16) begin
      send_item(1'b1, rnd_sample(), rnd_sample(), rnd_sample());
      return;
    end
    zs = ($urandom_range(0, 3) == 0) ? dip_thr : z_high();
    send_item(1'b0, rnd_sample(), rnd_sample(), zs);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_items);
    int target;
    target = items_sent + n_items;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    while (items_sent < target) send_gesture();
    in_valid <= 1'b0;
  endtask

  // Waits until every queued result has come back, then lets a trailing
  // sample finish inside the block, since samples produce no result.
  task automatic wait_idle();
    while (pattern_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic signed [SW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dip_thr = value;
  endtask

  // ---------------------------------------------------------------------------
  // Output side. The receiver stalls at random, or for a long counted stretch
  // whenever the stimulus asks for one through hold_req.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  function automatic void cmp_field(string what, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endfunction

  // Every accepted result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    pat_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pattern_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result at position %0d, expected none, actual x %0d",
                   $time, position, x_value);
      end else begin
        e = pattern_q.pop_front();
        cmp_field("direction_label", e.dir, direction_label);
        cmp_field("pattern_number", e.pnum, pattern_number);
        cmp_field("position", e.pos, position);
        cmp_field("x_value", e.xv, x_value);
        cmp_field("y_value", e.yv, y_value);
        cmp_field("is_padding", e.pad, is_padding);
        cmp_field("truncated", e.trunc, truncated);
        cmp_field("last", e.fin, last);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table at the reset threshold of -176. The comments give the
  // segment each cut closes.
  // ---------------------------------------------------------------------------
  step_t steps [18] = '{
    // End of data straight after reset: an empty, all-padding pattern.
    '{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 2'd0, 16'd0, 8'd0},
    '{1'b0, 16'sd32767, 16'sh8000, 16'sd0, 1'b0, 2'd0, 16'd0, 8'd0},
    '{1'b0, 16'sh8000, 16'sd32767, 16'sd32767, 1'b0, 2'd0, 16'd0, 8'd0},
    // z equal to the threshold opens the window but cannot close it.
    '{1'b0, 16'sd1, 16'sd2, -16'sd176, 1'b0, 2'd0, 16'd0, 8'd0},
    '{1'b0, -16'sd1, -16'sd1, 16'sh8000, 1'b0, 2'd0, 16'd0, 8'd0},
    // Tie at the minimum: the later sample becomes the cut.
    '{1'b0, 16'sd5, 16'sd6, 16'sh8000, 1'b0, 2'd0, 16'd0, 8'd0},
    '{1'b0, 16'sd7, 16'sd8, -16'sd177, 1'b0, 2'd0, 16'd0, 8'd0},
    // Closing at exactly the threshold; four samples precede the later minimum.
    '{1'b0, 16'sd9, 16'sd10, -16'sd176, 1'b1, 2'd0, 16'd0, 8'd4},
    '{1'b0, 16'sh5555, 16'shAAAA, -16'sd200, 1'b0, 2'd0, 16'd0, 8'd0},
    '{1'b0, 16'shAAAA, 16'sh5555, 16'sd32767, 1'b1, 2'd1, 16'd1, 8'd3},
    '{1'b0, 16'sd11, 16'sd12, -16'sd300, 1'b0, 2'd0, 16'd0, 8'd0},
    // End of data inside a window cuts at the minimum.
    '{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 2'd2, 16'd1, 8'd2},
    '{1'b0, 16'sd100, 16'sd200, 16'sd100, 1'b0, 2'd0, 16'd0, 8'd0},
    '{1'b0, -16'sd100, -16'sd200, 16'sd50, 1'b0, 2'd0, 16'd0, 8'd0},
    // End of data while waiting keeps every held sample.
    '{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 2'd0, 16'd0, 8'd2},
    '{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 2'd0, 16'd0, 8'd0},
    '{1'b0, 16'sd3, 16'sd4, -16'sd500, 1'b0, 2'd0, 16'd0, 8'd0},
    '{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 2'd0, 16'd0, 8'd0}
  };

  initial begin
    int base;
    dip_thr = THR_RESET;
    restart_stream();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows. Typed rows overwrite the header fields of the pattern
    // just queued, so the block is held to the hand-written values.
    foreach (steps[r]) begin
      send_item(steps[r].eod, steps[r].xs, steps[r].ys, steps[r].zs);
      if (steps[r].hand_chk) begin
        base = pattern_q.size() - PATTERN_LEN;
        for (int i = base; i < pattern_q.size(); i++) begin
          pattern_q[i].dir = steps[r].dir;
          pattern_q[i].pnum = steps[r].pnum;
          pattern_q[i].pad = (pattern_q[i].pos >= steps[r].len);
          pattern_q[i].trunc = (steps[r].len > PATTERN_LEN);
          if (pattern_q[i].pad) begin
            pattern_q[i].xv = '0;
            pattern_q[i].yv = '0;
          end
        end
      end
    end
    in_valid <= 1'b0;
    wait_idle();

    // Random gestures at the reset threshold, back to back.
    run_phase(0, 0, 30);
    wait_idle();

    // Highest threshold: every sample opens a window, only full scale closes it.
    write_threshold(16'sd32767);
    run_phase(56, 0, 30);
    wait_idle();

    // Lowest threshold: only full-scale negative z opens, any next sample closes.
    write_threshold(16'sh8000);
    run_phase(0, 56, 30);
    wait_idle();

    write_threshold(rnd_sample());
    run_phase(36, 36, 35);
    wait_idle();

    // Back-pressure: a segment longer than the pattern builds up, then the
    // receiver holds off just before the cut, so the pattern waits in the
    // block and the following transactions are stalled at its input.
    write_threshold(16'sd0);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (55) send_item(1'b0, rnd_sample(), rnd_sample(), z_high());
    hold_req <= hold_req + 1;
    send_item(1'b0, rnd_sample(), rnd_sample(), z_low());
    send_item(1'b0, rnd_sample(), rnd_sample(), z_high());
    run_phase(0, 0, 25);
    wait_idle();

    write_threshold(THR_RESET);
    run_phase(0, 0, 25);
    send_item(1'b1, rnd_sample(), rnd_sample(), rnd_sample());
    in_valid <= 1'b0;
    wait_idle();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
